FILE: src/assert_macros.svh
// Assertion macros shared by the sample ring log modules.
// Each macro expects the module to have clk_i and an active-low rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define SRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sample ring log: assertion failed");

// A same-cycle implication.
`define SRL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sample ring log: assertion failed");

// An implication checked in the next cycle.
`define SRL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sample ring log: assertion failed");

`endif

FILE: src/srl_pkg.sv
// Shared constants, types and codes for the sample ring log.
// Used by srl_minmax and sample_ring_log_with_range; depends on nothing.
package srl_pkg;

  localparam int unsigned DEPTH   = 128;
  localparam int unsigned ADDR_W  = $clog2(DEPTH);
  localparam int unsigned ADDR_W1 = ADDR_W + 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned AGE_W   = 7;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned CMP_W   = (CNT_W > AGE_W) ? CNT_W : AGE_W;

  // Narrowest span a range query reports, and half of it.
  localparam int unsigned SPAN_MIN  = 16;
  localparam int unsigned HALF_SPAN = SPAN_MIN / 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_APPEND = 2'd0,
    MODE_READ   = 2'd1,
    MODE_RANGE  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    MM_NOP,
    MM_FIRST,
    MM_FEED,
    MM_MID,
    MM_WIDEN
  } mm_op_e;

  typedef struct packed {
    mm_op_e                    op;
    logic signed [TEMP_W-1:0]  value;
  } mm_ctrl_t;

  typedef struct packed {
    logic                      xflag;
    logic signed [TEMP_W-1:0]  xtal;
    logic signed [TEMP_W-1:0]  die;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

FILE: src/srl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; the read data holds while no read is issued.
module srl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/srl_minmax.sv
// Shared min/max accumulator with the final span widening step.
// Depends on srl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srl_minmax (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  srl_pkg::mm_ctrl_t                     ctrl_i,
  output logic signed [srl_pkg::TEMP_W-1:0]     lo_o,
  output logic signed [srl_pkg::TEMP_W-1:0]     hi_o
);

  logic signed [srl_pkg::TEMP_W-1:0] lo_q, lo_d;
  logic signed [srl_pkg::TEMP_W-1:0] hi_q, hi_d;
  logic signed [srl_pkg::TEMP_W-1:0] mid_q, mid_d;
  logic                              small_q, small_d;
  logic signed [srl_pkg::TEMP_W:0]   diff_w;
  logic signed [srl_pkg::TEMP_W:0]   sum_w;
  logic signed [srl_pkg::TEMP_W:0]   sum_half_w;
  logic signed [srl_pkg::TEMP_W:0]   wlo_w;
  logic signed [srl_pkg::TEMP_W:0]   whi_w;

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    small_d = small_q;
    diff_w     = {hi_q[srl_pkg::TEMP_W-1], hi_q} - {lo_q[srl_pkg::TEMP_W-1], lo_q};
    sum_w      = {hi_q[srl_pkg::TEMP_W-1], hi_q} + {lo_q[srl_pkg::TEMP_W-1], lo_q};
    sum_half_w = sum_w >>> 1;
    wlo_w = {mid_q[srl_pkg::TEMP_W-1], mid_q} - (srl_pkg::TEMP_W+1)'(srl_pkg::HALF_SPAN);
    whi_w = {mid_q[srl_pkg::TEMP_W-1], mid_q} + (srl_pkg::TEMP_W+1)'(srl_pkg::HALF_SPAN);
    case (ctrl_i.op)
      srl_pkg::MM_FIRST: begin
        lo_d = ctrl_i.value;
        hi_d = ctrl_i.value;
      end
      srl_pkg::MM_FEED: begin
        if (ctrl_i.value < lo_q) begin
          lo_d = ctrl_i.value;
        end
        if (ctrl_i.value > hi_q) begin
          hi_d = ctrl_i.value;
        end
      end
      srl_pkg::MM_MID: begin
        // The arithmetic shift gives the floor of the midpoint for negative sums too.
        small_d = diff_w < (srl_pkg::TEMP_W+1)'(srl_pkg::SPAN_MIN);
        mid_d   = sum_half_w[srl_pkg::TEMP_W-1:0];
      end
      srl_pkg::MM_WIDEN: begin
        if (small_q) begin
          // A carry into the top bit that disagrees with the sign means the bound
          // left the 16-bit range, so it saturates.
          lo_d = (wlo_w[srl_pkg::TEMP_W] != wlo_w[srl_pkg::TEMP_W-1]) ?
                 {1'b1, {(srl_pkg::TEMP_W-1){1'b0}}} : wlo_w[srl_pkg::TEMP_W-1:0];
          hi_d = (whi_w[srl_pkg::TEMP_W] != whi_w[srl_pkg::TEMP_W-1]) ?
                 {1'b0, {(srl_pkg::TEMP_W-1){1'b1}}} : whi_w[srl_pkg::TEMP_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    small_q <= small_d;
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;

  `SRL_ASSERT_NEXT(a_lo_not_above_hi, ctrl_i.op != srl_pkg::MM_NOP, lo_q <= hi_q)
  `SRL_ASSERT_NEXT(a_first_sets_both, ctrl_i.op == srl_pkg::MM_FIRST, lo_q == hi_q)
  `SRL_ASSERT(a_op_known, ctrl_i.op <= srl_pkg::MM_WIDEN)

endmodule

FILE: src/sample_ring_log_with_range.sv
// Sample ring log: request sequencer, ring pointers and output register.
// Depends on srl_pkg, srl_ram, srl_minmax and assert_macros.svh.
//
//   channel  handshake              payload
//   in       in_valid_i/in_stall_o  mode_i, die_temp_i, xtal_present_i, xtal_temp_i,
//                                   age_index_i
//   out      out_valid_o/out_stall_i ok_o, die_out_o, xtal_valid_o, xtal_out_o,
//                                   range_low_o, range_high_o, sample_count_o
//
// An append, a read or an unused mode passes acceptance, then result load. A range query
// scans each held sample (die, then crystal), then runs midpoint and widen; an empty one
// skips these. The single RAM read port and shared min/max unit take one value per cycle.
// Reset empties the ring (write pointer and count); the RAM itself is not cleared.
// A stalled result waits in the output register while the next request is taken; that
// request's result then waits, with the input stalled, until the register empties.
`include "assert_macros.svh"

module sample_ring_log_with_range (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [srl_pkg::MODE_W-1:0]             mode_i,
  input  logic signed [srl_pkg::TEMP_W-1:0]      die_temp_i,
  input  logic                                   xtal_present_i,
  input  logic signed [srl_pkg::TEMP_W-1:0]      xtal_temp_i,
  input  logic [srl_pkg::AGE_W-1:0]              age_index_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   ok_o,
  output logic signed [srl_pkg::TEMP_W-1:0]      die_out_o,
  output logic                                   xtal_valid_o,
  output logic signed [srl_pkg::TEMP_W-1:0]      xtal_out_o,
  output logic signed [srl_pkg::TEMP_W-1:0]      range_low_o,
  output logic signed [srl_pkg::TEMP_W-1:0]      range_high_o,
  output logic [srl_pkg::COUNT_W-1:0]            sample_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SC_DIE,
    ST_SC_XT,
    ST_MID,
    ST_WIDEN,
    ST_DONE
  } state_e;

  state_e                               state_q;
  logic [srl_pkg::ADDR_W-1:0]           head_q;
  logic [srl_pkg::CNT_W-1:0]            cnt_q;
  logic [srl_pkg::MODE_W-1:0]           op_q;
  logic                                 ok_q;
  logic                                 first_q;
  logic [srl_pkg::ADDR_W-1:0]           ptr_q;
  logic [srl_pkg::CNT_W-1:0]            left_q;
  logic                                 out_valid_q;
  logic                                 res_ok_q;
  logic signed [srl_pkg::TEMP_W-1:0]    res_die_q;
  logic                                 res_xv_q;
  logic signed [srl_pkg::TEMP_W-1:0]    res_xtal_q;
  logic signed [srl_pkg::TEMP_W-1:0]    res_lo_q;
  logic signed [srl_pkg::TEMP_W-1:0]    res_hi_q;
  logic [srl_pkg::COUNT_W-1:0]          res_cnt_q;

  logic                                 accept;
  logic                                 full;
  logic                                 age_ok;
  logic                                 done_ld;
  logic [srl_pkg::ADDR_W-1:0]           base;
  logic [srl_pkg::ADDR_W1-1:0]          slot_sum;
  logic [srl_pkg::ADDR_W1-1:0]          slot_wrap;
  logic [srl_pkg::ADDR_W-1:0]           read_slot;
  logic                                 ram_we;
  logic                                 ram_re;
  logic [srl_pkg::ADDR_W-1:0]           ram_raddr;
  srl_pkg::entry_t                      wentry;
  logic [srl_pkg::ENTRY_W-1:0]          ram_rdata;
  srl_pkg::entry_t                      rentry;
  srl_pkg::mm_ctrl_t                    mm_ctrl;
  logic signed [srl_pkg::TEMP_W-1:0]    mm_lo;
  logic signed [srl_pkg::TEMP_W-1:0]    mm_hi;
  logic                                 res_ok;
  logic signed [srl_pkg::TEMP_W-1:0]    res_die;
  logic                                 res_xv;
  logic signed [srl_pkg::TEMP_W-1:0]    res_xtal;
  logic signed [srl_pkg::TEMP_W-1:0]    res_lo;
  logic signed [srl_pkg::TEMP_W-1:0]    res_hi;

  function automatic logic [srl_pkg::ADDR_W-1:0] ring_next(
    input logic [srl_pkg::ADDR_W-1:0] p
  );
    return (p == srl_pkg::ADDR_W'(srl_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign full       = (cnt_q == srl_pkg::CNT_W'(srl_pkg::DEPTH));
  assign age_ok     = srl_pkg::CMP_W'(age_index_i) < srl_pkg::CMP_W'(cnt_q);

  // Once the ring has wrapped, the oldest sample sits at the write pointer.
  assign base      = full ? head_q : '0;
  assign slot_sum  = {1'b0, base} + srl_pkg::ADDR_W1'(age_index_i);
  assign slot_wrap = (slot_sum >= srl_pkg::ADDR_W1'(srl_pkg::DEPTH)) ?
                     slot_sum - srl_pkg::ADDR_W1'(srl_pkg::DEPTH) : slot_sum;
  assign read_slot = slot_wrap[srl_pkg::ADDR_W-1:0];

  assign wentry.xflag = xtal_present_i;
  assign wentry.xtal  = xtal_temp_i;
  assign wentry.die   = die_temp_i;
  assign ram_we       = accept & (mode_i == srl_pkg::MODE_APPEND);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_q;
    if (state_q == ST_IDLE) begin
      if (accept && mode_i == srl_pkg::MODE_READ && age_ok) begin
        ram_re    = 1'b1;
        ram_raddr = read_slot;
      end else if (accept && mode_i == srl_pkg::MODE_RANGE && cnt_q != '0) begin
        ram_re    = 1'b1;
        ram_raddr = base;
      end
    end else if (state_q == ST_SC_XT && left_q != '0) begin
      ram_re = 1'b1;
    end
  end

  srl_ram #(
    .WIDTH (srl_pkg::ENTRY_W),
    .DEPTH (srl_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_q),
    .wdata_i (wentry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rentry = srl_pkg::entry_t'(ram_rdata);

  // The shared unit sees each held entry's die value, then its crystal value if present.
  always_comb begin
    mm_ctrl.op    = srl_pkg::MM_NOP;
    mm_ctrl.value = rentry.die;
    case (state_q)
      ST_SC_DIE: mm_ctrl.op = first_q ? srl_pkg::MM_FIRST : srl_pkg::MM_FEED;
      ST_SC_XT: begin
        mm_ctrl.op    = rentry.xflag ? srl_pkg::MM_FEED : srl_pkg::MM_NOP;
        mm_ctrl.value = rentry.xtal;
      end
      ST_MID:   mm_ctrl.op = srl_pkg::MM_MID;
      ST_WIDEN: mm_ctrl.op = srl_pkg::MM_WIDEN;
      default: begin
      end
    endcase
  end

  srl_minmax u_minmax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mm_ctrl),
    .lo_o   (mm_lo),
    .hi_o   (mm_hi)
  );

  always_comb begin
    res_ok   = 1'b0;
    res_die  = '0;
    res_xv   = 1'b0;
    res_xtal = '0;
    res_lo   = '0;
    res_hi   = '0;
    case (op_q)
      srl_pkg::MODE_APPEND: res_ok = 1'b1;
      srl_pkg::MODE_READ: begin
        res_ok = ok_q;
        if (ok_q) begin
          res_die = rentry.die;
          res_xv  = rentry.xflag;
          if (rentry.xflag) begin
            res_xtal = rentry.xtal;
          end
        end
      end
      srl_pkg::MODE_RANGE: begin
        res_ok = ok_q;
        if (ok_q) begin
          res_lo = mm_lo;
          res_hi = mm_hi;
        end
      end
      default: begin
      end
    endcase
  end

  assign done_ld = (state_q == ST_DONE) & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      op_q        <= '0;
      ok_q        <= 1'b0;
      first_q     <= 1'b0;
      ptr_q       <= '0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
      res_ok_q    <= 1'b0;
      res_die_q   <= '0;
      res_xv_q    <= 1'b0;
      res_xtal_q  <= '0;
      res_lo_q    <= '0;
      res_hi_q    <= '0;
      res_cnt_q   <= '0;
    end else begin
      // A result taken this cycle empties the register unless the next one loads now.
      if (out_valid_q && !out_stall_i && !done_ld) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q <= mode_i;
            case (mode_i)
              srl_pkg::MODE_APPEND: begin
                head_q  <= ring_next(head_q);
                if (!full) begin
                  cnt_q <= cnt_q + 1'b1;
                end
                state_q <= ST_DONE;
              end
              srl_pkg::MODE_READ: begin
                ok_q    <= age_ok;
                state_q <= ST_DONE;
              end
              srl_pkg::MODE_RANGE: begin
                ok_q <= (cnt_q != '0);
                if (cnt_q != '0) begin
                  state_q <= ST_SC_DIE;
                  first_q <= 1'b1;
                  ptr_q   <= ring_next(base);
                  left_q  <= cnt_q - 1'b1;
                end else begin
                  state_q <= ST_DONE;
                end
              end
              default: begin
                ok_q    <= 1'b0;
                state_q <= ST_DONE;
              end
            endcase
          end
        end
        ST_SC_DIE: begin
          first_q <= 1'b0;
          state_q <= ST_SC_XT;
        end
        ST_SC_XT: begin
          if (left_q != '0) begin
            left_q  <= left_q - 1'b1;
            ptr_q   <= ring_next(ptr_q);
            state_q <= ST_SC_DIE;
          end else begin
            state_q <= ST_MID;
          end
        end
        ST_MID:   state_q <= ST_WIDEN;
        ST_WIDEN: state_q <= ST_DONE;
        ST_DONE: begin
          if (done_ld) begin
            out_valid_q <= 1'b1;
            res_ok_q    <= res_ok;
            res_die_q   <= res_die;
            res_xv_q    <= res_xv;
            res_xtal_q  <= res_xtal;
            res_lo_q    <= res_lo;
            res_hi_q    <= res_hi;
            res_cnt_q   <= srl_pkg::COUNT_W'(cnt_q);
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign ok_o           = res_ok_q;
  assign die_out_o      = res_die_q;
  assign xtal_valid_o   = res_xv_q;
  assign xtal_out_o     = res_xtal_q;
  assign range_low_o    = res_lo_q;
  assign range_high_o   = res_hi_q;
  assign sample_count_o = res_cnt_q;

  `SRL_ASSERT(a_count_bounded, cnt_q <= srl_pkg::CNT_W'(srl_pkg::DEPTH))
  `SRL_ASSERT_IMPLY(a_head_tracks_count, !full, head_q == srl_pkg::ADDR_W'(cnt_q))
  `SRL_ASSERT(a_no_read_on_append, !(ram_we && ram_re))
  `SRL_ASSERT_IMPLY(a_result_from_done, $rose(out_valid_q), $past(state_q == ST_DONE))

endmodule
